// ===== design/jse_pkg.sv =====
// Shared types and constants for the JSON string escaper.
// Used by jse_front, jse_queue, jse_back and json_string_escaper_top.
`default_nettype none

package jse_pkg;

   localparam int ByteWidth    = 8;
   localparam int LenWidth     = 16;
   localparam int QueueDepth   = 4;
   localparam int StepWidth    = 3;

   localparam logic [LenWidth-1:0] CapacityReset = 16'd256;

   localparam logic [ByteWidth-1:0] ChrQuote     = 8'h22;
   localparam logic [ByteWidth-1:0] ChrBackslash = 8'h5C;
   localparam logic [ByteWidth-1:0] ChrNewline   = 8'h0A;
   localparam logic [ByteWidth-1:0] ChrReturn    = 8'h0D;
   localparam logic [ByteWidth-1:0] ChrTab       = 8'h09;
   localparam logic [ByteWidth-1:0] ChrLowerN    = 8'h6E;
   localparam logic [ByteWidth-1:0] ChrLowerR    = 8'h72;
   localparam logic [ByteWidth-1:0] ChrLowerT    = 8'h74;
   localparam logic [ByteWidth-1:0] ChrLowerU    = 8'h75;
   localparam logic [ByteWidth-1:0] ChrZero      = 8'h30;
   localparam logic [ByteWidth-1:0] ChrLowerA    = 8'h61;
   localparam logic [ByteWidth-1:0] CtrlLimit    = 8'h20;

   // Output sizes of each kind of item
   localparam logic [2:0] NeedPlain   = 3'd1;
   localparam logic [2:0] NeedPair    = 3'd2;
   localparam logic [2:0] NeedUnicode = 3'd6;

   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_PAIR,
      KIND_UNICODE,
      KIND_TERM
   } kind_type;

   // One classified item between front and back.
   // data: plain byte, second byte of a pair, or the control byte for \u00xx.
   typedef struct packed {
      kind_type                kind;
      logic [ByteWidth-1:0]    data;
      logic [LenWidth-1:0]     length;
   } entry_type;

endpackage

`default_nettype wire

// ===== design/json_string_escaper_top.sv =====
// JSON string escaper, top level. A source byte's entry is written into the
// queue, then expanded into the output register. Throughput: one source byte
// per cycle while each gives one output byte; the output side gives one byte
// per cycle while rsp_tready is high, so a pair escape gives two output bytes
// and a \u00xx escape six. The four-entry queue takes up short bursts, then the
// input stalls. Reset (synchronous, active high) sets capacity to 256, clears
// the length and halt state and empties the queue and the output register.
`default_nettype none

module json_string_escaper_top #(
   parameter int QUEUE_DEPTH = jse_pkg::QueueDepth
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [jse_pkg::LenWidth-1:0]  csr_wr_data,   // capacity
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [7:0]                    req_tdata,     // [7:0] src_byte
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [23:0]                        rsp_tdata,     // [7:0] out_byte, [23:8] out_length
   output logic                               rsp_tlast      // is_last
);
   import jse_pkg::*;

   logic                 push, pop, full, empty;
   entry_type            push_entry, head;
   logic [ByteWidth-1:0] out_byte;
   logic [LenWidth-1:0]  out_length;

   jse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .src_byte    (req_tdata),
      .queue_full  (full),
      .push        (push),
      .push_entry  (push_entry)
   );

   jse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head       (head),
      .empty      (empty)
   );

   jse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_byte   (out_byte),
      .is_last    (rsp_tlast),
      .out_length (out_length)
   );

   assign rsp_tdata = {out_length, out_byte};

endmodule

`default_nettype wire

// ===== design/jse_front.sv =====
// Front end of the JSON string escaper: takes source bytes, classifies them,
// checks them against the capacity and pushes work entries. Depends on jse_pkg.
`default_nettype none

module jse_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [jse_pkg::LenWidth-1:0]  csr_wr_data,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [jse_pkg::ByteWidth-1:0] src_byte,
   input  wire logic                          queue_full,
   output logic                               push,
   output jse_pkg::entry_type                 push_entry
);
   import jse_pkg::*;

   logic [LenWidth-1:0] capacity_ff, capacity_in;
   logic [LenWidth-1:0] write_position_ff, write_position_in;
   logic                halted_ff, halted_in;

   logic                accept;
   logic [2:0]          need;
   kind_type            kind;
   logic [ByteWidth-1:0] data;
   logic [LenWidth:0]   cap_eff;
   logic [LenWidth:0]   end_pos;
   logic                fits;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      kind = KIND_PLAIN;
      need = NeedPlain;
      data = src_byte;
      case (src_byte)
         ChrQuote, ChrBackslash: begin
            kind = KIND_PAIR;
            need = NeedPair;
         end
         ChrNewline: begin
            kind = KIND_PAIR;
            need = NeedPair;
            data = ChrLowerN;
         end
         ChrReturn: begin
            kind = KIND_PAIR;
            need = NeedPair;
            data = ChrLowerR;
         end
         ChrTab: begin
            kind = KIND_PAIR;
            need = NeedPair;
            data = ChrLowerT;
         end
         default: begin
            if (src_byte < CtrlLimit) begin
               kind = KIND_UNICODE;
               need = NeedUnicode;
            end
         end
      endcase
   end

   // capacity zero behaves as one; fits when end position stays below capacity
   assign cap_eff = (capacity_ff == '0) ? (LenWidth+1)'(1) : {1'b0, capacity_ff};
   assign end_pos = {1'b0, write_position_ff} + (LenWidth+1)'(need);
   assign fits    = end_pos < cap_eff;

   always_comb begin
      capacity_in       = csr_wr_en ? csr_wr_data : capacity_ff;
      write_position_in = write_position_ff;
      halted_in         = halted_ff;
      push              = 1'b0;
      push_entry.kind   = kind;
      push_entry.data   = data;
      push_entry.length = '0;
      if (accept) begin
         if (src_byte == '0) begin
            push              = 1'b1;
            push_entry.kind   = KIND_TERM;
            push_entry.data   = '0;
            push_entry.length = write_position_ff;
            write_position_in = '0;
            halted_in         = 1'b0;
         end else if (!halted_ff) begin
            if (fits) begin
               push              = 1'b1;
               write_position_in = end_pos[LenWidth-1:0];
            end else begin
               halted_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff       <= CapacityReset;
         write_position_ff <= '0;
         halted_ff         <= 1'b0;
      end else begin
         capacity_ff       <= capacity_in;
         write_position_ff <= write_position_in;
         halted_ff         <= halted_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/jse_queue.sv =====
// Short register queue of classified entries between front and back.
// Depends on jse_pkg for the entry type.
`default_nettype none

module jse_queue #(
   parameter int DEPTH = jse_pkg::QueueDepth
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire jse_pkg::entry_type push_entry,
   output logic                    full,
   input  wire logic               pop,
   output jse_pkg::entry_type      head,
   output logic                    empty
);
   import jse_pkg::*;

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0]   LastPtr  = PtrWidth'(DEPTH - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(DEPTH);

   entry_type                 slot_ff [DEPTH];
   logic [PtrWidth-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]     count_ff, count_in;
   logic                      do_push, do_pop;

   assign full    = (count_ff == FullCount);
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== design/jse_back.sv =====
// Back end of the JSON string escaper: expands queued entries into output
// bytes, one per cycle while rsp_tready is high, into the output register. Depends on jse_pkg.
`default_nettype none

module jse_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire jse_pkg::entry_type            head,
   input  wire logic                          empty,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [jse_pkg::ByteWidth-1:0]      out_byte,
   output logic                               is_last,
   output logic [jse_pkg::LenWidth-1:0]       out_length
);
   import jse_pkg::*;

   logic                 valid_ff, valid_in;
   logic [ByteWidth-1:0] byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic [LenWidth-1:0]  len_ff, len_in;
   logic [StepWidth-1:0] step_ff, step_in;

   logic                 load;
   logic [StepWidth-1:0] last_step;
   logic [ByteWidth-1:0] exp_byte;
   logic [ByteWidth-1:0] hex_lo;
   logic [3:0]           nib;

   assign nib    = head.data[3:0];
   assign hex_lo = (nib < 4'd10) ? ChrZero + ByteWidth'(nib)
                                 : ChrLowerA + ByteWidth'(nib - 4'd10);

   always_comb begin
      case (head.kind)
         KIND_PAIR:    last_step = StepWidth'(NeedPair - 3'd1);
         KIND_UNICODE: last_step = StepWidth'(NeedUnicode - 3'd1);
         default:      last_step = '0;
      endcase
   end

   always_comb begin
      exp_byte = head.data;
      case (head.kind)
         KIND_PAIR: begin
            exp_byte = (step_ff == '0) ? ChrBackslash : head.data;
         end
         KIND_UNICODE: begin
            case (step_ff)
               3'd0:    exp_byte = ChrBackslash;
               3'd1:    exp_byte = ChrLowerU;
               3'd2:    exp_byte = ChrZero;
               3'd3:    exp_byte = ChrZero;
               3'd4:    exp_byte = ChrZero + ByteWidth'(head.data[4]);
               default: exp_byte = hex_lo;
            endcase
         end
         KIND_TERM:  exp_byte = '0;
         default:    exp_byte = head.data;
      endcase
   end

   // output register loads when empty or its transfer completes
   assign load = !valid_ff || rsp_tready;
   assign pop  = load && !empty && (step_ff == last_step);

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      len_in   = len_ff;
      step_in  = step_ff;
      if (load) begin
         valid_in = !empty;
         if (!empty) begin
            byte_in = exp_byte;
            last_in = (head.kind == KIND_TERM);
            len_in  = (head.kind == KIND_TERM) ? head.length : '0;
            step_in = (step_ff == last_step) ? '0 : step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      len_ff  <= len_in;
   end

   assign rsp_tvalid = valid_ff;
   assign out_byte   = byte_ff;
   assign is_last    = last_ff;
   assign out_length = len_ff;

endmodule

`default_nettype wire
